[hdl/sltd_pkg.sv]
// Shared types, codes and compare functions for the sorted line table.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package sltd_pkg;

    localparam int COORD_WIDTH         = 16;
    localparam int COLOR_WIDTH         = 24;
    localparam int EPS_WIDTH           = 8;
    localparam int POS_WIDTH           = 10;
    localparam int ECOUNT_WIDTH        = 11;
    localparam int DROP_WIDTH          = 16;
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam logic [DROP_WIDTH-1:0] DROP_MAX = '1;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // result status codes
    localparam logic [2:0] STS_INSERTED  = 3'd0;
    localparam logic [2:0] STS_DEGEN     = 3'd1;
    localparam logic [2:0] STS_DUPLICATE = 3'd2;
    localparam logic [2:0] STS_FULL      = 3'd3;
    localparam logic [2:0] STS_PASS      = 3'd4;
    localparam logic [2:0] STS_READ_OK   = 3'd5;
    localparam logic [2:0] STS_CLEARED   = 3'd6;
    localparam logic [2:0] STS_BAD_INDEX = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_SORT_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_DEDUP_ENABLE = 2'd1;
    localparam logic [1:0] CFG_EPSILON      = 2'd2;

    // tolerant compare codes
    localparam logic [1:0] CMP_EQ = 2'd0;
    localparam logic [1:0] CMP_LT = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [COLOR_WIDTH-1:0]        color_t;

    typedef struct packed {
        logic [1:0]           req_type;
        coord_t               x_start;
        coord_t               y_start;
        coord_t               x_end;
        coord_t               y_end;
        color_t               color_start;
        color_t               color_end;
        logic [POS_WIDTH-1:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]              status;
        logic [POS_WIDTH-1:0]    position;
        coord_t                  out_x_start;
        coord_t                  out_y_start;
        coord_t                  out_x_end;
        coord_t                  out_y_end;
        color_t                  out_color_start;
        color_t                  out_color_end;
        logic [ECOUNT_WIDTH-1:0] entry_count;
        logic [DROP_WIDTH-1:0]   removed_count;
    } out_item_t;

    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        color_t c0;
        color_t c1;
    } line_t;

    typedef struct packed {
        logic load_new;
        logic take_left;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_FETCH,
        ST_CMP,
        ST_FINISH,
        ST_OUT
    } state_t;

    function automatic logic [1:0] tol_cmp(coord_t a, coord_t b, logic [EPS_WIDTH-1:0] e);
        logic signed [COORD_WIDTH+1:0] as;
        logic signed [COORD_WIDTH+1:0] bs;
        logic signed [COORD_WIDTH+1:0] es;
        logic [1:0]                    r;
        as = (COORD_WIDTH+2)'(a);
        bs = (COORD_WIDTH+2)'(b);
        es = $signed((COORD_WIDTH+2)'(e));
        if (as < bs - es)
            r = CMP_LT;
        else if (as > bs + es)
            r = CMP_GT;
        else
            r = CMP_EQ;
        return r;
    endfunction

    function automatic logic [1:0] line_cmp(line_t a, line_t b, logic [EPS_WIDTH-1:0] e);
        logic [1:0] r;
        r = tol_cmp(a.x0, b.x0, e);
        if (r == CMP_EQ) r = tol_cmp(a.y0, b.y0, e);
        if (r == CMP_EQ) r = tol_cmp(a.x1, b.x1, e);
        if (r == CMP_EQ) r = tol_cmp(a.y1, b.y1, e);
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/sltd_cell.sv]
// One table entry of the sorted line table: holds a line, takes the new line
// or its left neighbor's line on insert. Depends on sltd_pkg.
`default_nettype none

module sltd_cell
    import sltd_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_ctl_t ctl,
    input  wire line_t     new_line,
    input  wire line_t     left_line,
    output line_t          q
);

    line_t line_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load_new)
            line_reg <= new_line;
        else if (ctl.take_left)
            line_reg <= left_line;
    end

    assign q = line_reg;

endmodule

`default_nettype wire

[hdl/sorted_line_table_dedup.sv]
// Sorted line table: a row of entry cells plus a search sequencer and result register.
// Depends on sltd_pkg and sltd_cell.
//
// The block keeps up to TABLE_DEPTH line segments in a row of cells, sorted by a
// tolerant order on (x0, y0, x1, y1). It works on one transaction at a time. An
// insert passes a setup state, a cell read and a compare for each binary-search
// step, a state that places the line, in which every cell behind the insert point
// takes its left neighbor's line at once, and a state that loads the result
// register. A read passes setup, cell read, compare and load; clear, passthrough,
// degenerate lines and bad requests pass only setup and load. The search loop sets
// the insert time. A new transaction is accepted once the previous result is loaded
// into the output register, even while that result still waits to be taken.
`default_nettype none

module sorted_line_table_dedup
    import sltd_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_item_t             in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_item_t                 out_item,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [EPS_WIDTH-1:0] cfg_data
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    state_t state_reg, state_next;

    in_item_t              req_reg;
    line_t                 line_reg, line_next;
    line_t                 rd_line_reg;
    logic [IW-1:0]         addr_reg, addr_next;
    logic [CW-1:0]         first_reg, first_next;
    logic [CW-1:0]         last_reg, last_next;
    logic [CW-1:0]         mid_reg, mid_next;
    logic                  same_reg, same_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [DROP_WIDTH-1:0] drop_reg, drop_next;
    logic [2:0]            res_status_reg, res_status_next;
    logic [POS_WIDTH-1:0]  res_pos_reg, res_pos_next;
    line_t                 res_line_reg, res_line_next;
    out_item_t             out_item_reg;
    logic                  out_valid_reg;
    logic                  sort_reg, dedup_reg;
    logic [EPS_WIDTH-1:0]  eps_reg;

    // setup-cycle datapath
    logic signed [COORD_WIDTH+1:0] fx, fy, tx, ty, es, dxs, dys;
    logic [COORD_WIDTH:0]          adx, ady;
    logic [15:0]                   dx2, dy2, ee;
    logic [16:0]                   sq;
    logic                          degen, keep_order;
    line_t                         ordered;

    // search datapath
    logic [1:0]  cmp_r;
    logic [CW-1:0] f_n, l_n;
    logic [CW:0] mid_sum;
    logic        is_dup, is_full, ins_fire, out_load;

    line_t     cell_q [TABLE_DEPTH];
    cell_ctl_t cell_ctl [TABLE_DEPTH];

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    // endpoint analysis on the held request
    always_comb
    begin
        fx  = (COORD_WIDTH+2)'(req_reg.x_start);
        fy  = (COORD_WIDTH+2)'(req_reg.y_start);
        tx  = (COORD_WIDTH+2)'(req_reg.x_end);
        ty  = (COORD_WIDTH+2)'(req_reg.y_end);
        es  = $signed((COORD_WIDTH+2)'(eps_reg));
        dxs = fx - tx;
        dys = fy - ty;
        adx = (dxs < 0) ? (COORD_WIDTH+1)'(-dxs) : (COORD_WIDTH+1)'(dxs);
        ady = (dys < 0) ? (COORD_WIDTH+1)'(-dys) : (COORD_WIDTH+1)'(dys);
        dx2 = 16'(adx[7:0]) * 16'(adx[7:0]);
        dy2 = 16'(ady[7:0]) * 16'(ady[7:0]);
        sq  = 17'(dx2) + 17'(dy2);
        ee  = 16'(eps_reg) * 16'(eps_reg);
        degen = (adx <= (COORD_WIDTH+1)'(255)) && (ady <= (COORD_WIDTH+1)'(255))
                && (sq < 17'(ee));
        keep_order = (fx < tx - es)
                     || ((adx < (COORD_WIDTH+1)'(eps_reg)) && (fy < ty - es));
        if (keep_order)
        begin
            ordered.x0 = req_reg.x_start;
            ordered.y0 = req_reg.y_start;
            ordered.x1 = req_reg.x_end;
            ordered.y1 = req_reg.y_end;
            ordered.c0 = req_reg.color_start;
            ordered.c1 = req_reg.color_end;
        end
        else
        begin
            ordered.x0 = req_reg.x_end;
            ordered.y0 = req_reg.y_end;
            ordered.x1 = req_reg.x_start;
            ordered.y1 = req_reg.y_start;
            ordered.c0 = req_reg.color_end;
            ordered.c1 = req_reg.color_start;
        end
    end

    // search step and insert decision
    always_comb
    begin
        cmp_r = line_cmp(line_reg, rd_line_reg, eps_reg);
        f_n   = first_reg;
        l_n   = last_reg;
        case (cmp_r)
            CMP_LT:  l_n = mid_reg;
            CMP_GT:  f_n = mid_reg + CW'(1);
            default:
            begin
                f_n = mid_reg;
                l_n = mid_reg;
            end
        endcase
        mid_sum  = (CW+1)'(f_n) + (CW+1)'(l_n);
        is_dup   = dedup_reg && (count_reg != '0) && same_reg;
        is_full  = (count_reg >= DEPTH_C);
        ins_fire = (state_reg == ST_FINISH) && !is_dup && !is_full;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_PREP;
            ST_PREP:
            begin
                state_next = ST_OUT;
                if (req_reg.req_type == REQ_READ)
                begin
                    if (CW'(req_reg.read_index) < count_reg
                        && (CW > POS_WIDTH || 11'(req_reg.read_index) < 11'(count_reg)))
                        state_next = ST_FETCH;
                end
                else if (req_reg.req_type == REQ_INSERT && sort_reg && !degen)
                    state_next = (count_reg != '0) ? ST_FETCH : ST_FINISH;
            end
            ST_FETCH:
                state_next = ST_CMP;
            ST_CMP:
                if (req_reg.req_type == REQ_READ)
                    state_next = ST_OUT;
                else if (l_n > f_n)
                    state_next = ST_FETCH;
                else
                    state_next = ST_FINISH;
            ST_FINISH:
                state_next = ST_OUT;
            ST_OUT:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb
    begin
        line_next       = line_reg;
        addr_next       = addr_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        mid_next        = mid_reg;
        same_next       = same_reg;
        count_next      = count_reg;
        drop_next       = drop_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_line_next   = res_line_reg;
        case (state_reg)
            ST_PREP:
            begin
                res_line_next = '0;
                res_pos_next  = '0;
                case (req_reg.req_type)
                    REQ_INSERT:
                    begin
                        if (!sort_reg)
                        begin
                            res_status_next           = STS_PASS;
                            res_line_next.x0          = req_reg.x_start;
                            res_line_next.y0          = req_reg.y_start;
                            res_line_next.x1          = req_reg.x_end;
                            res_line_next.y1          = req_reg.y_end;
                            res_line_next.c0          = req_reg.color_start;
                            res_line_next.c1          = req_reg.color_end;
                        end
                        else if (degen)
                        begin
                            res_status_next = STS_DEGEN;
                            drop_next = (drop_reg == DROP_MAX) ? drop_reg
                                                               : drop_reg + 1'b1;
                        end
                        else
                        begin
                            line_next  = ordered;
                            first_next = '0;
                            last_next  = count_reg;
                            mid_next   = count_reg >> 1;
                            addr_next  = IW'(count_reg >> 1);
                            same_next  = 1'b0;
                        end
                    end
                    REQ_READ:
                    begin
                        res_pos_next    = req_reg.read_index;
                        res_status_next = STS_BAD_INDEX;
                        addr_next       = IW'(req_reg.read_index);
                    end
                    REQ_CLEAR:
                    begin
                        res_status_next = STS_CLEARED;
                        count_next      = '0;
                        drop_next       = '0;
                    end
                    default:
                        res_status_next = STS_BAD_INDEX;
                endcase
            end
            ST_CMP:
            begin
                if (req_reg.req_type == REQ_READ)
                begin
                    res_status_next = STS_READ_OK;
                    res_line_next   = rd_line_reg;
                end
                else
                begin
                    first_next = f_n;
                    last_next  = l_n;
                    mid_next   = mid_sum[CW:1];
                    addr_next  = IW'(mid_sum[CW:1]);
                    if (cmp_r == CMP_EQ)
                        same_next = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (is_dup)
                begin
                    res_status_next = STS_DUPLICATE;
                    res_pos_next    = POS_WIDTH'(mid_reg);
                    drop_next = (drop_reg == DROP_MAX) ? drop_reg : drop_reg + 1'b1;
                end
                else if (is_full)
                    res_status_next = STS_FULL;
                else
                begin
                    res_status_next = STS_INSERTED;
                    res_pos_next    = POS_WIDTH'(mid_reg);
                    res_line_next   = line_reg;
                    count_next      = count_reg + CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
            sort_reg      <= 1'b0;
            dedup_reg     <= 1'b0;
            eps_reg       <= EPS_WIDTH'(1);
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SORT_ENABLE:  sort_reg  <= cfg_data[0];
                    CFG_DEDUP_ENABLE: dedup_reg <= cfg_data[0];
                    CFG_EPSILON:      eps_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            req_reg <= in_item;
        line_reg       <= line_next;
        addr_reg       <= addr_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        mid_reg        <= mid_next;
        same_reg       <= same_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_line_reg   <= res_line_next;
        rd_line_reg    <= cell_q[addr_reg];
        if (out_load)
        begin
            out_item_reg.status          <= res_status_reg;
            out_item_reg.position        <= res_pos_reg;
            out_item_reg.out_x_start     <= res_line_reg.x0;
            out_item_reg.out_y_start     <= res_line_reg.y0;
            out_item_reg.out_x_end       <= res_line_reg.x1;
            out_item_reg.out_y_end       <= res_line_reg.y1;
            out_item_reg.out_color_start <= res_line_reg.c0;
            out_item_reg.out_color_end   <= res_line_reg.c1;
            out_item_reg.entry_count     <= ECOUNT_WIDTH'(count_reg);
            out_item_reg.removed_count   <= drop_reg;
        end
    end

    // row of entry cells; cells behind the insert point shift right by one
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        assign cell_ctl[i].load_new  = ins_fire && (CW'(i) == mid_reg);
        assign cell_ctl[i].take_left = ins_fire && (CW'(i) > mid_reg)
                                       && (CW'(i) <= count_reg);
        if (i == 0)
        begin : g_head
            sltd_cell u_cell (
                .clk       (clk),
                .ctl       (cell_ctl[i]),
                .new_line  (line_reg),
                .left_line (line_reg),
                .q         (cell_q[i])
            );
        end
        else
        begin : g_body
            sltd_cell u_cell (
                .clk       (clk),
                .ctl       (cell_ctl[i]),
                .new_line  (line_reg),
                .left_line (cell_q[i-1]),
                .q         (cell_q[i])
            );
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("line count above table depth");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP && req_reg.req_type == REQ_INSERT)
        |-> (mid_reg < last_reg && mid_reg >= first_reg))
        else $error("search midpoint outside window");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ins_fire |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the table");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP && req_reg.req_type == REQ_CLEAR)
        |=> (count_reg == '0 && drop_reg == '0))
        else $error("clear left state behind");

endmodule

`default_nettype wire

[tb/sltd_checker.sv]
// Checker for the sorted line table: watches both channels and the config port,
// predicts every result with its own table model and compares field by field.
// Depends on sltd_pkg.
`timescale 1ns / 1ps

module sltd_checker
    import sltd_pkg::*;
#(
    parameter int DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire in_item_t             in_item,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire out_item_t            out_item,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [EPS_WIDTH-1:0] cfg_data,
    output int                        fail_count,
    output int                        pending,
    output int                        status_seen [8]
);

    line_t                   lines [DEPTH];
    int                      nlines;
    int                      ndropped;
    logic                    sort_on;
    logic                    dedup_on;
    logic [EPS_WIDTH-1:0]    eps;
    out_item_t               expected_results [$];

    // tolerant compare on wide signed values: -1 before, 1 after, 0 equal
    function automatic int coord_order(longint a, longint b, longint e);
        if (a < b - e) return -1;
        if (a > b + e) return 1;
        return 0;
    endfunction

    function automatic int line_order(line_t a, line_t b, longint e);
        int r;
        r = coord_order(a.x0, b.x0, e);
        if (r == 0) r = coord_order(a.y0, b.y0, e);
        if (r == 0) r = coord_order(a.x1, b.x1, e);
        if (r == 0) r = coord_order(a.y1, b.y1, e);
        return r;
    endfunction

    function automatic void count_drop();
        if (ndropped < 65535) ndropped++;
    endfunction

    function automatic out_item_t table_response(in_item_t it);
        out_item_t r;
        line_t     l;
        longint    e, fx, fy, tx, ty, dx, dy;
        int        lo, hi, mid;
        logic      same;
        r = '0;
        e = eps;
        fx = it.x_start; fy = it.y_start; tx = it.x_end; ty = it.y_end;
        same = 1'b0;
        if (it.req_type == REQ_INSERT) begin
            if (!sort_on) begin
                r.status = STS_PASS;
                r.out_x_start = it.x_start; r.out_y_start = it.y_start;
                r.out_x_end = it.x_end; r.out_y_end = it.y_end;
                r.out_color_start = it.color_start; r.out_color_end = it.color_end;
            end
            else begin
                dx = (fx > tx) ? fx - tx : tx - fx;
                dy = (fy > ty) ? fy - ty : ty - fy;
                if (dx <= 255 && dy <= 255 && dx * dx + dy * dy < e * e) begin
                    count_drop();
                    r.status = STS_DEGEN;
                end
                else begin
                    if (fx < tx - e || (dx < e && fy < ty - e))
                        l = '{it.x_start, it.y_start, it.x_end, it.y_end,
                              it.color_start, it.color_end};
                    else
                        l = '{it.x_end, it.y_end, it.x_start, it.y_start,
                              it.color_end, it.color_start};
                    lo = 0;
                    hi = nlines;
                    mid = (lo + hi) / 2;
                    while (hi > lo) begin
                        case (line_order(l, lines[mid], e))
                            -1: hi = mid;
                            1: lo = mid + 1;
                            default:
                            begin
                                lo = mid;
                                hi = mid;
                                same = 1'b1;
                            end
                        endcase
                        mid = (lo + hi) / 2;
                    end
                    if (dedup_on && nlines >= 1 && same) begin
                        count_drop();
                        r.status = STS_DUPLICATE;
                        r.position = mid[POS_WIDTH-1:0];
                    end
                    else if (nlines >= DEPTH) begin
                        r.status = STS_FULL;
                    end
                    else begin
                        for (int k = nlines; k > mid; k--)
                            lines[k] = lines[k-1];
                        lines[mid] = l;
                        nlines++;
                        r.status = STS_INSERTED;
                        r.position = mid[POS_WIDTH-1:0];
                        r.out_x_start = l.x0; r.out_y_start = l.y0;
                        r.out_x_end = l.x1; r.out_y_end = l.y1;
                        r.out_color_start = l.c0; r.out_color_end = l.c1;
                    end
                end
            end
        end
        else if (it.req_type == REQ_READ) begin
            r.position = it.read_index;
            if (it.read_index < nlines) begin
                l = lines[it.read_index];
                r.status = STS_READ_OK;
                r.out_x_start = l.x0; r.out_y_start = l.y0;
                r.out_x_end = l.x1; r.out_y_end = l.y1;
                r.out_color_start = l.c0; r.out_color_end = l.c1;
            end
            else begin
                r.status = STS_BAD_INDEX;
            end
        end
        else if (it.req_type == REQ_CLEAR) begin
            nlines = 0;
            ndropped = 0;
            r.status = STS_CLEARED;
        end
        else begin
            r.status = STS_BAD_INDEX;
        end
        r.entry_count = nlines[ECOUNT_WIDTH-1:0];
        r.removed_count = ndropped[DROP_WIDTH-1:0];
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t w;
        if (!rst_n) begin
            nlines = 0;
            ndropped = 0;
            sort_on = 1'b0;
            dedup_on = 1'b0;
            eps = 8'd1;
            fail_count = 0;
            pending = 0;
            expected_results.delete();
            foreach (status_seen[i]) status_seen[i] = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SORT_ENABLE:  sort_on = cfg_data[0];
                    CFG_DEDUP_ENABLE: dedup_on = cfg_data[0];
                    CFG_EPSILON:      eps = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else begin
                    w = expected_results.pop_front();
                    status_seen[w.status]++;
                    check_field("status", w.status, out_item.status);
                    check_field("position", w.position, out_item.position);
                    check_field("out_x_start", w.out_x_start, out_item.out_x_start);
                    check_field("out_y_start", w.out_y_start, out_item.out_y_start);
                    check_field("out_x_end", w.out_x_end, out_item.out_x_end);
                    check_field("out_y_end", w.out_y_end, out_item.out_y_end);
                    check_field("out_color_start", w.out_color_start,
                                out_item.out_color_start);
                    check_field("out_color_end", w.out_color_end, out_item.out_color_end);
                    check_field("entry_count", w.entry_count, out_item.entry_count);
                    check_field("removed_count", w.removed_count, out_item.removed_count);
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(table_response(in_item));
            pending = expected_results.size();
        end
    end

endmodule

[tb/testbench.sv]
// Stimulus and verdict for the sorted line table: directed and random requests,
// config phases with random idling and back pressure. Depends on sltd_pkg,
// sltd_checker and the block under test.
`timescale 1ns / 1ps

module testbench;
    import sltd_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_item;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_item;
    logic                 cfg_we;
    logic [1:0]           cfg_index;
    logic [EPS_WIDTH-1:0] cfg_data;
    int                   fail_count;
    int                   pending;
    int                   status_seen [8];
    int                   idle_cycles;
    int                   sent;
    logic                 hold_off;
    logic                 stim_done;

    // recent insert requests, reused to build near-duplicates
    in_item_t             history [$];

    sorted_line_table_dedup uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    sltd_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .status_seen(status_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // valid stays high after acceptance until the next call or drain() drops it
    task automatic send(in_item_t it);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [EPS_WIDTH-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic set_mode(logic srt, logic ddp, logic [EPS_WIDTH-1:0] e);
        drain();
        write_reg(CFG_SORT_ENABLE, {7'd0, srt});
        write_reg(CFG_DEDUP_ENABLE, {7'd0, ddp});
        write_reg(CFG_EPSILON, e);
        cfg_we <= 1'b0;
    endtask

    function automatic in_item_t make_line(logic signed [15:0] xa, logic signed [15:0] ya,
                                           logic signed [15:0] xb, logic signed [15:0] yb);
        in_item_t it;
        it = '0;
        it.req_type = REQ_INSERT;
        it.x_start = xa; it.y_start = ya; it.x_end = xb; it.y_end = yb;
        it.color_start = 24'($urandom);
        it.color_end = 24'($urandom);
        it.read_index = 10'($urandom);
        return it;
    endfunction

    function automatic in_item_t random_request();
        in_item_t it;
        int       sel;
        int       spread;
        sel = $urandom_range(0, 99);
        it = '0;
        it.color_start = 24'($urandom);
        it.color_end = 24'($urandom);
        it.read_index = 10'($urandom);
        if (sel < 10) begin
            it.req_type = REQ_READ;
            if ($urandom_range(0, 3) != 0) it.read_index = 10'($urandom_range(0, 40));
        end
        else if (sel < 12) begin
            it.req_type = REQ_CLEAR;
        end
        else if (sel < 14) begin
            it.req_type = 2'd3;
        end
        else if (sel < 40 && history.size() > 0) begin
            // near copy of an earlier line, sometimes with x_start set to x_end and x_end from the oldest entry
            it = history[$urandom_range(0, history.size() - 1)];
            it.x_start += 16'($signed($urandom_range(0, 6)) - 3);
            it.y_end += 16'($signed($urandom_range(0, 6)) - 3);
            if ($urandom_range(0, 1)) begin
                it.x_start = it.x_end; it.x_end = history[0].x_start;
            end
        end
        else begin
            it.req_type = REQ_INSERT;
            spread = ($urandom_range(0, 3) == 0) ? 65535 : 64;
            if (spread == 65535) begin
                it.x_start = 16'($urandom); it.y_start = 16'($urandom);
                it.x_end = 16'($urandom); it.y_end = 16'($urandom);
            end
            else begin
                it.x_start = 16'($urandom_range(0, 128)) - 16'sd64;
                it.y_start = 16'($urandom_range(0, 128)) - 16'sd64;
                it.x_end = it.x_start + 16'($urandom_range(0, 40)) - 16'sd20;
                it.y_end = it.y_start + 16'($urandom_range(0, 40)) - 16'sd20;
            end
        end
        if (it.req_type == REQ_INSERT) begin
            history.push_back(it);
            if (history.size() > 32) void'(history.pop_front());
        end
        return it;
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int wait_n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_off) begin
                wait_n = 300;
                hold_off = 1'b0;
            end
            else begin
                wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            end
            if (wait_n > 0) begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // watchdog on accepted transactions
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        in_item_t it;
        int       ends_wait;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_SORT_ENABLE;
        cfg_data = '0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset mode: passthrough of extremes, plus a read, clear, unused code
        send(make_line(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF));
        it = make_line(0, 0, 0, 0);
        it.req_type = REQ_READ;
        it.read_index = 10'h3FF;
        send(it);
        it.req_type = 2'd3;
        send(it);
        it.req_type = REQ_CLEAR;
        send(it);

        // sorted with dedup: degenerate, swaps, duplicate, reads
        set_mode(1'b1, 1'b1, 8'd4);
        send(make_line(0, 0, 1, 1));
        send(make_line(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000));
        send(make_line(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF));
        send(make_line(100, 10, 102, 50));
        send(make_line(102, 50, 100, 10));
        send(make_line(100, 12, 102, 48));
        send(make_line(5, 0, 200, 0));
        send(make_line(-50, -50, 300, 300));
        for (int i = 0; i < 6; i++) begin
            it = make_line(0, 0, 0, 0);
            it.req_type = REQ_READ;
            it.read_index = 10'(i);
            send(it);
        end

        // large tolerance, dedup off; then zero tolerance
        set_mode(1'b1, 1'b0, 8'd255);
        send(make_line(0, 0, 180, 180));
        send(make_line(0, 0, 255, 255));
        send(make_line(100, 100, 100, 100));
        set_mode(1'b1, 1'b1, 8'd0);
        send(make_line(7, 7, 7, 7));
        send(make_line(7, 7, 7, 7));

        // back pressure: receiver holds off while requests keep coming
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++) send(random_request());

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_mode(1'b1, 1'b1, 8'd2);
                1: set_mode(1'b1, 1'b0, 8'd0);
                2: set_mode(1'b0, 1'b1, 8'($urandom));
                3: set_mode(1'b1, 1'b1, 8'd255);
                4: set_mode(1'b1, 1'b0, 8'($urandom_range(0, 16)));
                default: set_mode(1'b1, 1'b1, 8'd1);
            endcase
            for (int i = 0; i < 80; i++) send(random_request());
        end

        // clear, then a burst of lines in ascending order and a read past the end
        set_mode(1'b1, 1'b0, 8'd0);
        it = make_line(0, 0, 0, 0);
        it.req_type = REQ_CLEAR;
        send(it);
        for (int i = 0; i < 40; i++) begin
            it = make_line(16'(i * 3 - 1600), 16'($urandom), 16'($urandom), 16'($urandom));
            it.x_end = it.x_start + 16'sd2;
            send(it);
        end
        it.req_type = REQ_READ;
        it.read_index = 10'h3FF;
        send(it);
        in_valid <= 1'b0;

        ends_wait = 0;
        @(posedge clk);
        while (pending != 0 && ends_wait < 100000) begin
            @(posedge clk);
            ends_wait++;
        end
        repeat (40) @(posedge clk);
        stim_done = 1'b1;
        $display("Covered %0d requests over several modes; results: ins %0d degen %0d dup %0d",
                 sent, status_seen[STS_INSERTED], status_seen[STS_DEGEN],
                 status_seen[STS_DUPLICATE]);
        $display("full %0d pass %0d read %0d clear %0d bad %0d", status_seen[STS_FULL],
                 status_seen[STS_PASS], status_seen[STS_READ_OK],
                 status_seen[STS_CLEARED], status_seen[STS_BAD_INDEX]);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
